[design/evcef_pkg.sv]
// Shared types, constants and helper functions of the charge-enable controller.
`default_nettype none

package evcef_pkg;

    // Widths of the word fields and of the configuration registers.
    localparam int CurrentWidth = 17;
    localparam int SecondsWidth = 8;
    localparam int AmpsWidth    = 7;
    localparam int CfgAddrWidth = 2;
    localparam int CfgDataWidth = 8;

    // Milliamperes in one ampere; the stop threshold is held in mA.
    localparam logic [CurrentWidth-1:0] MA_PER_AMP = CurrentWidth'(1000);

    // Seconds counters saturate here.
    localparam logic [SecondsWidth-1:0] SEC_COUNT_MAX = '1;

    // A current history that can never be below any threshold.
    localparam logic [CurrentWidth-1:0] CURRENT_ALL_ONES = '1;

    // Configuration register addresses.
    localparam logic [CfgAddrWidth-1:0] REG_MIN_STOP_AMPS = 2'd0;
    localparam logic [CfgAddrWidth-1:0] REG_PLUG_ENABLE   = 2'd1;
    localparam logic [CfgAddrWidth-1:0] REG_EOC_SAMPLE    = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [AmpsWidth-1:0]    RESET_MIN_STOP_AMPS = 7'd6;
    localparam logic [SecondsWidth-1:0] RESET_PLUG_ENABLE   = 8'd30;
    localparam logic [SecondsWidth-1:0] RESET_EOC_SAMPLE    = 8'd30;

    // Force mode codes.
    localparam logic [1:0] FORCE_NONE = 2'd0;
    localparam logic [1:0] FORCE_MIN  = 2'd1;
    localparam logic [1:0] FORCE_ALL  = 2'd2;

    // Charge state codes as seen on the result channel.
    localparam logic [2:0] CODE_OFF        = 3'd0;
    localparam logic [2:0] CODE_FORCE_WAIT = 3'd1;
    localparam logic [2:0] CODE_CAL_WAIT   = 3'd2;
    localparam logic [2:0] CODE_CHARGING   = 3'd3;
    localparam logic [2:0] CODE_EOC_LOW    = 3'd4;

    typedef enum logic [4:0] {
        ST_OFF        = 5'b00001,
        ST_FORCE_WAIT = 5'b00010,
        ST_CAL_WAIT   = 5'b00100,
        ST_CHARGING   = 5'b01000,
        ST_EOC_LOW    = 5'b10000
    } charge_state_t;

    typedef struct packed {
        logic                    toggle_force;
        logic                    calendar_allows;
        logic                    date_lost;
        logic                    ev_charging;
        logic [CurrentWidth-1:0] current_milliamps;
        logic                    plug_present;
        logic                    second_pulse;
    } tick_t;

    typedef struct packed {
        logic [2:0] charge_state;
        logic [1:0] force_mode;
        logic       charger_enable;
    } result_t;

    // Settings as the core sees them; the threshold is already in mA.
    typedef struct packed {
        logic [CurrentWidth-1:0] limit_ma;
        logic [SecondsWidth-1:0] plug_enable_seconds;
        logic [SecondsWidth-1:0] eoc_sample_seconds;
    } cfg_t;

    function automatic logic [2:0] state_code(charge_state_t st);
        logic [2:0] code;
        case (st)
            ST_OFF:        code = CODE_OFF;
            ST_FORCE_WAIT: code = CODE_FORCE_WAIT;
            ST_CAL_WAIT:   code = CODE_CAL_WAIT;
            ST_CHARGING:   code = CODE_CHARGING;
            ST_EOC_LOW:    code = CODE_EOC_LOW;
            default:       code = CODE_OFF;
        endcase
        return code;
    endfunction

    function automatic logic [1:0] rotate_force(logic [1:0] fm);
        logic [1:0] nf;
        case (fm)
            FORCE_NONE: nf = FORCE_MIN;
            FORCE_MIN:  nf = FORCE_ALL;
            default:    nf = FORCE_NONE;
        endcase
        return nf;
    endfunction

endpackage

`default_nettype wire

[design/evcef_ifs.sv]
// Handshake channels of the charge-enable controller: tick words, result words, settings.
`default_nettype none

interface evcef_tick_if;
    logic             valid;
    logic             ready;
    evcef_pkg::tick_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface evcef_result_if;
    logic               valid;
    logic               ready;
    evcef_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface evcef_cfg_if;
    logic                                 valid;
    logic                                 ready;
    logic [evcef_pkg::CfgAddrWidth-1:0]   addr;
    logic [evcef_pkg::CfgDataWidth-1:0]   wdata;

    modport source (output valid, output addr, output wdata, input ready);
    modport sink (input valid, input addr, input wdata, output ready);
endinterface

`default_nettype wire

[design/evcef_cfg_regs.sv]
// Settings registers of the charge-enable controller.
`default_nettype none

module evcef_cfg_regs
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    evcef_cfg_if.sink            cfg,
    output evcef_pkg::cfg_t      cfg_val
);

    logic [evcef_pkg::CurrentWidth-1:0] limit_ma_reg;
    logic [evcef_pkg::SecondsWidth-1:0] plug_enable_reg;
    logic [evcef_pkg::SecondsWidth-1:0] eoc_sample_reg;
    logic [evcef_pkg::CurrentWidth-1:0] limit_ma_next;
    logic                               wr_en;

    assign cfg.ready = 1'b1;
    assign wr_en     = cfg.valid && cfg.ready;

    // The threshold is kept in milliamperes so the core only compares.
    assign limit_ma_next = evcef_pkg::CurrentWidth'(
        {{(evcef_pkg::CurrentWidth - evcef_pkg::AmpsWidth){1'b0}},
         cfg.wdata[evcef_pkg::AmpsWidth-1:0]} * evcef_pkg::MA_PER_AMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_ma_reg    <= evcef_pkg::CurrentWidth'(
                {{(evcef_pkg::CurrentWidth - evcef_pkg::AmpsWidth){1'b0}},
                 evcef_pkg::RESET_MIN_STOP_AMPS} * evcef_pkg::MA_PER_AMP);
            plug_enable_reg <= evcef_pkg::RESET_PLUG_ENABLE;
            eoc_sample_reg  <= evcef_pkg::RESET_EOC_SAMPLE;
        end
        else if (wr_en)
        begin
            case (cfg.addr)
                evcef_pkg::REG_MIN_STOP_AMPS: limit_ma_reg    <= limit_ma_next;
                evcef_pkg::REG_PLUG_ENABLE:   plug_enable_reg <= cfg.wdata;
                evcef_pkg::REG_EOC_SAMPLE:    eoc_sample_reg  <= cfg.wdata;
                default:
                begin
                end
            endcase
        end
    end

    assign cfg_val.limit_ma            = limit_ma_reg;
    assign cfg_val.plug_enable_seconds = plug_enable_reg;
    assign cfg_val.eoc_sample_seconds  = eoc_sample_reg;

endmodule

`default_nettype wire

[design/evcef_core.sv]
// Charge state machine, force mode, plug-in timer and end-of-charge sampling.
`default_nettype none

module evcef_core
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire evcef_pkg::tick_t   tick_word,
    input  wire evcef_pkg::cfg_t    cfg_val,
    output evcef_pkg::result_t      res_word
);

    evcef_pkg::charge_state_t           state_reg, state_next;
    logic [1:0]                         force_reg, force_next;
    logic                               plug_seen_reg, plug_seen_next;
    logic                               plug_run_reg, plug_run_next;
    logic [evcef_pkg::SecondsWidth-1:0] plug_elapsed_reg, plug_elapsed_next;
    logic [evcef_pkg::SecondsWidth-1:0] eoc_elapsed_reg, eoc_elapsed_next;
    logic [evcef_pkg::CurrentWidth-1:0] prev_current_reg, prev_current_next;
    logic [evcef_pkg::SecondsWidth-1:0] eoc_counted;
    logic                               plug_active;
    logic                               forced;
    logic                               cal_ok;
    logic                               cur_low;
    logic                               prev_low;
    logic                               enable;

    assign cur_low  = tick_word.current_milliamps < cfg_val.limit_ma;
    assign prev_low = prev_current_reg < cfg_val.limit_ma;
    assign cal_ok   = !tick_word.date_lost && tick_word.calendar_allows;

    always_comb
    begin
        // Plug-in timer: a new plug restarts it without counting that tick.
        plug_run_next     = plug_run_reg;
        plug_elapsed_next = plug_elapsed_reg;
        if (tick_word.plug_present && !plug_seen_reg)
        begin
            plug_run_next     = 1'b1;
            plug_elapsed_next = '0;
        end
        else if (plug_run_reg && tick_word.second_pulse
                 && plug_elapsed_reg != evcef_pkg::SEC_COUNT_MAX)
        begin
            plug_elapsed_next = plug_elapsed_reg + 1'b1;
        end
        plug_seen_next = tick_word.plug_present;
        plug_active    = plug_run_next && (plug_elapsed_next < cfg_val.plug_enable_seconds);
        if (!plug_active)
        begin
            plug_run_next = 1'b0;
        end

        if (tick_word.second_pulse && eoc_elapsed_reg != evcef_pkg::SEC_COUNT_MAX)
        begin
            eoc_counted = eoc_elapsed_reg + 1'b1;
        end
        else
        begin
            eoc_counted = eoc_elapsed_reg;
        end
        eoc_elapsed_next = eoc_counted;

        force_next = tick_word.toggle_force ? evcef_pkg::rotate_force(force_reg) : force_reg;
        forced     = force_next != evcef_pkg::FORCE_NONE;

        prev_current_next = (state_reg == evcef_pkg::ST_CHARGING)
                          ? prev_current_reg : evcef_pkg::CURRENT_ALL_ONES;

        state_next = state_reg;
        enable     = 1'b0;
        case (state_reg)
            evcef_pkg::ST_OFF:
            begin
                if (forced)
                begin
                    state_next = evcef_pkg::ST_FORCE_WAIT;
                end
                else if (cal_ok)
                begin
                    state_next = evcef_pkg::ST_CAL_WAIT;
                end
                enable = plug_active;
            end
            evcef_pkg::ST_FORCE_WAIT:
            begin
                if (!forced)
                begin
                    state_next = evcef_pkg::ST_OFF;
                end
                else if (tick_word.ev_charging)
                begin
                    eoc_elapsed_next = '0;
                    state_next       = evcef_pkg::ST_CHARGING;
                end
                enable = 1'b1;
            end
            evcef_pkg::ST_CAL_WAIT:
            begin
                if (forced)
                begin
                    state_next = evcef_pkg::ST_FORCE_WAIT;
                end
                else if (!cal_ok)
                begin
                    state_next = evcef_pkg::ST_OFF;
                end
                else if (tick_word.ev_charging)
                begin
                    eoc_elapsed_next = '0;
                    state_next       = evcef_pkg::ST_CHARGING;
                end
                enable = 1'b1;
            end
            evcef_pkg::ST_CHARGING:
            begin
                // Leave conditions look at the force mode held before this tick's press.
                if (!tick_word.ev_charging)
                begin
                    state_next = evcef_pkg::ST_CAL_WAIT;
                    force_next = evcef_pkg::FORCE_NONE;
                end
                else if (force_reg != evcef_pkg::FORCE_ALL && !cal_ok)
                begin
                    state_next = evcef_pkg::ST_OFF;
                    force_next = evcef_pkg::FORCE_NONE;
                end
                else if (force_reg == evcef_pkg::FORCE_NONE
                         && eoc_counted >= cfg_val.eoc_sample_seconds)
                begin
                    eoc_elapsed_next  = '0;
                    prev_current_next = tick_word.current_milliamps;
                    if (cur_low && prev_low)
                    begin
                        state_next = evcef_pkg::ST_EOC_LOW;
                        force_next = evcef_pkg::FORCE_NONE;
                    end
                end
                enable = 1'b1;
            end
            evcef_pkg::ST_EOC_LOW:
            begin
                if (forced)
                begin
                    state_next = evcef_pkg::ST_FORCE_WAIT;
                end
                else if (!cal_ok)
                begin
                    state_next = evcef_pkg::ST_OFF;
                end
                enable = 1'b0;
            end
            default:
            begin
                state_next = evcef_pkg::ST_OFF;
                enable     = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= evcef_pkg::ST_OFF;
            force_reg        <= evcef_pkg::FORCE_NONE;
            plug_seen_reg    <= 1'b0;
            plug_run_reg     <= 1'b0;
            plug_elapsed_reg <= '0;
            eoc_elapsed_reg  <= '0;
            prev_current_reg <= evcef_pkg::CURRENT_ALL_ONES;
        end
        else if (fire)
        begin
            state_reg        <= state_next;
            force_reg        <= force_next;
            plug_seen_reg    <= plug_seen_next;
            plug_run_reg     <= plug_run_next;
            plug_elapsed_reg <= plug_elapsed_next;
            eoc_elapsed_reg  <= eoc_elapsed_next;
            prev_current_reg <= prev_current_next;
        end
    end

    assign res_word.charge_state   = evcef_pkg::state_code(state_next);
    assign res_word.force_mode     = force_next;
    assign res_word.charger_enable = enable;

endmodule

`default_nettype wire

[design/ev_charge_enable_fsm_top.sv]
// Top level of the charge-enable controller: tick, result and settings channels.
//
// The tick channel takes one control tick per word: button toggle, calendar
// permission, date-lost flag, vehicle-charging flag, current in mA, plug level
// and a one-second pulse. For each tick word one result word leaves on the
// result channel with the new charge state, the new force mode and the
// charger enable decided from the state at the start of the tick.
// A tick word is held in an input register, worked through the state machine
// and written to the result register, from which its result word is offered on
// the result channel; one tick per cycle is sustained while the receiver holds
// ready high. The state update in the core is the only loop and it closes
// through the core's own state registers.
// If the receiver holds ready low, the result register keeps its word and the
// input register still takes one more tick; only then does the tick channel
// drop ready. The settings channel is always ready and should be written only
// while no tick is in flight. Reset clears both registers, puts the machine in
// the off state with no force and loads the default settings.
`default_nettype none

module ev_charge_enable_fsm_top
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    evcef_tick_if.sink       tick,
    evcef_result_if.source   result,
    evcef_cfg_if.sink        cfg
);

    logic                 tick_valid_reg, tick_valid_next;
    evcef_pkg::tick_t     tick_data_reg;
    logic                 res_valid_reg, res_valid_next;
    evcef_pkg::result_t   res_data_reg;
    evcef_pkg::result_t   res_word;
    evcef_pkg::cfg_t      cfg_val;
    logic                 tick_take;
    logic                 advance;

    evcef_cfg_regs u_cfg_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .cfg_val (cfg_val)
    );

    evcef_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .tick_word (tick_data_reg),
        .cfg_val   (cfg_val),
        .res_word  (res_word)
    );

    assign advance    = tick_valid_reg && (!res_valid_reg || result.ready);
    assign tick.ready = !tick_valid_reg || advance;
    assign tick_take  = tick.valid && tick.ready;

    assign tick_valid_next = tick_take || (tick_valid_reg && !advance);
    assign res_valid_next  = advance || (res_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            tick_valid_reg <= tick_valid_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_take)
        begin
            tick_data_reg <= tick.data;
        end
        if (advance)
        begin
            res_data_reg <= res_word;
        end
    end

    assign result.valid = res_valid_reg;
    assign result.data  = res_data_reg;

    // A word worked through the core must show up as a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result.valid)
        else $error("worked tick did not produce a result word");

    // The tick channel only stalls when both pipeline registers are occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        !tick.ready |-> (tick_valid_reg && res_valid_reg && !result.ready))
        else $error("tick channel stalled with room in the pipeline");

    // Resting at low-current end implies no force mode is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.data.charge_state == evcef_pkg::CODE_EOC_LOW)
        |-> (result.data.force_mode == evcef_pkg::FORCE_NONE))
        else $error("low-current end reported with a force mode set");

    // The unused force code never leaves the block.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.data.force_mode == evcef_pkg::FORCE_NONE
                          || result.data.force_mode == evcef_pkg::FORCE_MIN
                          || result.data.force_mode == evcef_pkg::FORCE_ALL))
        else $error("undefined force mode on result channel");

endmodule

`default_nettype wire
